// ===== rtl/csrw_pkg.sv =====
// shared types, constants and codes for the clock skew regression window
`timescale 1ns / 1ps

package csrw_pkg;

    localparam int WINDOW_MAX_DEF = 16;
    localparam int TIME_W         = 32;
    localparam int LEN_CFG_W      = 5;
    localparam int OFFSET_W       = 48;
    localparam int SKEW_W         = 64;
    localparam int APB_DATA_W     = 32;
    localparam int PADDR_W        = 3;
    localparam int DIV_W          = 128;
    localparam int DIV_CNT_W      = 8;

    // register indexes
    localparam logic [0:0] REG_WINDOW_LEN = 1'b0;

    typedef enum logic [1:0] {
        FIT_NOT_FULL = 2'd0,
        FIT_VALID    = 2'd1,
        FIT_DEN_ZERO = 2'd2
    } csrw_status_t;

    typedef struct packed {
        logic [TIME_W-1:0] global_time;
        logic [TIME_W-1:0] local_time;
        logic              clear_window;
    } csrw_sample_t;

    typedef struct packed {
        csrw_status_t               fit_status;
        logic signed [OFFSET_W-1:0] offset_q16;
        logic signed [SKEW_W-1:0]   skew_q32;
        logic [TIME_W-1:0]          local_mean;
    } csrw_fit_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] n;
        logic [DIV_W-1:0]     num;
        logic [DIV_W-1:0]     den;
    } csrw_div_req_t;

endpackage

// ===== rtl/csrw_div.sv =====
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module csrw_div
    import csrw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  csrw_div_req_t       req,
    output logic                busy,
    output logic [DIV_W-1:0]    quo,
    output logic [DIV_W-1:0]    rem
);

    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [DIV_W-1:0]     trial;
    logic                 fits;

    assign trial = {rem_reg[DIV_W-2:0], quo_reg[DIV_W-1]};
    assign fits  = (trial >= den_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (req.start)
        begin
            // numerator arrives left aligned, quotient shifts in from the bottom
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
            cnt_next  = req.n;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (trial - den_reg) : trial;
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/clock_skew_regression_window.sv =====
// sliding window of time samples with a least-squares offset and skew fit
//
// channel   dir   handshake                    payload
// sample    in    sample_valid/sample_ready    csrw_sample_t
// fit       out   fit_valid/fit_ready          csrw_fit_t
// apb       in    psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// a clear or a sample that leaves the window short skips the fit and goes straight to S_DONE
// a fit runs up to three divisions on the shared restoring divider (one quotient
// bit a cycle) and a pass over the samples on the 33x25 multiplier that forms
// four partial products per sample
// one transaction is worked at a time; sample_ready is low until the result is staged
// a finished result waits in the output register while the next sample is taken
// rst_n clears the window, window_len goes to 8 (WINDOW_MAX if smaller); stored samples are undefined until written
`timescale 1ns / 1ps

module clock_skew_regression_window
    import csrw_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  csrw_sample_t          sample,
    output logic                  fit_valid,
    input  logic                  fit_ready,
    output csrw_fit_t             fit
);

    localparam int DEPTH     = WINDOW_MAX + 1;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int LEN_W     = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W     = TIME_W + LEN_W;
    localparam int OFF_W     = 49;
    localparam int DD_W      = 50;
    localparam int DDM_W     = 49;
    localparam int DLM_W     = TIME_W + 1;
    localparam int MB_W      = 25;
    localparam int PROD_W    = DLM_W + MB_W;
    localparam int OFF_N     = SUM_W + 16;
    localparam int MEAN_N    = SUM_W;
    localparam int SKEW_N    = 97 + LEN_W;
    localparam int LEN_RESET = (8 > WINDOW_MAX) ? WINDOW_MAX : 8;

    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_P1        = 14'b00000000000010,
        S_OFF_GO    = 14'b00000000000100,
        S_OFF_WAIT  = 14'b00000000001000,
        S_MEAN_GO   = 14'b00000000010000,
        S_MEAN_WAIT = 14'b00000000100000,
        S_P2_RD     = 14'b00000001000000,
        S_P2_PREP   = 14'b00000010000000,
        S_P2_MUL    = 14'b00000100000000,
        S_P2_END    = 14'b00001000000000,
        S_SKEW_GO   = 14'b00010000000000,
        S_SKEW_WAIT = 14'b00100000000000,
        S_FIN       = 14'b01000000000000,
        S_DONE      = 14'b10000000000000
    } state_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] k);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(p) + (CNT_W + 1)'(k);
        if (s >= (CNT_W + 1)'(DEPTH))
        begin
            s = s - (CNT_W + 1)'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    state_t                   state_reg, state_next;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic [PTR_W-1:0]         base_reg, base_next;
    logic [PTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [LEN_W-1:0]         cnt_reg, cnt_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic                     acc_vld_reg, acc_vld_next;
    logic [1:0]               step_reg, step_next;
    logic [1:0]               acc_step_reg, acc_step_next;
    logic                     fit_valid_reg, fit_valid_next;

    logic [TIME_W-1:0]        gl_rd_reg, lo_rd_reg;
    logic signed [SUM_W-1:0]  sumd_reg, sumd_next;
    logic [SUM_W-1:0]         suml_reg, suml_next;
    logic signed [OFF_W-1:0]  off_reg, off_next;
    logic [TIME_W-1:0]        mean_reg, mean_next;
    logic [DLM_W-1:0]         dl_mag_reg, dl_mag_next;
    logic [DDM_W-1:0]         dd_mag_reg, dd_mag_next;
    logic                     neg_reg, neg_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic signed [DIV_W-1:0]  num_reg, num_next;
    logic [DIV_W-1:0]         den_reg, den_next;
    logic [DIV_W-1:0]         skq_reg, skq_next;
    csrw_status_t             status_reg, status_next;
    logic [SKEW_W-1:0]        skew_reg, skew_next;
    csrw_fit_t                fit_reg, fit_next;

    logic [TIME_W-1:0]        global_mem [DEPTH];
    logic [TIME_W-1:0]        local_mem [DEPTH];
    logic                     mem_we;
    logic [PTR_W-1:0]         wr_ptr;

    csrw_div_req_t            div_req;
    logic                     div_busy;
    logic [DIV_W-1:0]         div_quo;
    logic [DIV_W-1:0]         div_rem;

    logic                     cfg_we;
    logic [LEN_CFG_W-1:0]     cfg_val;
    logic                     take;
    logic signed [TIME_W-1:0] diff;
    logic signed [DLM_W-1:0]  dl;
    logic signed [DD_W-1:0]   dd;
    logic [DLM_W-1:0]         mul_a;
    logic [MB_W-1:0]          mul_b;
    logic [DIV_W-1:0]         acc_ext;
    logic [SUM_W-1:0]         sumd_mag;
    logic [OFF_W-1:0]         off_q;
    logic                     off_rnd;
    logic                     skew_rnd;
    logic                     num_neg;
    logic [DIV_W-1:0]         num_mag;
    logic [SKEW_W-1:0]        limit;
    logic [SKEW_W-1:0]        skew_sat;

    csrw_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .busy  (div_busy),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    assign pready       = 1'b1;
    assign prdata       = APB_DATA_W'(len_reg);
    assign cfg_we       = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LEN);
    assign cfg_val      = pwdata[LEN_CFG_W-1:0];
    assign sample_ready = (state_reg == S_IDLE);
    assign take         = sample_valid && sample_ready;
    assign fit_valid    = fit_valid_reg;
    assign fit          = fit_reg;

    // window entry v pairs local[v] with global[v+1]
    assign diff     = $signed(gl_rd_reg - lo_rd_reg);
    assign dl       = $signed({1'b0, lo_rd_reg}) - $signed({1'b0, mean_reg});
    assign dd       = $signed({{2{diff[TIME_W-1]}}, diff, 16'b0})
                      - $signed({off_reg[OFF_W-1], off_reg});
    assign mul_a    = dl_mag_reg;
    assign sumd_mag = sumd_reg[SUM_W-1] ? SUM_W'(-sumd_reg) : SUM_W'(sumd_reg);
    assign off_q    = div_quo[OFF_W-1:0];
    assign off_rnd  = ({div_rem[LEN_W-1:0], 1'b0} >= (LEN_W + 1)'(len_reg));
    assign skew_rnd = ({div_rem, 1'b0} >= {1'b0, den_reg});
    assign num_neg  = num_reg[DIV_W-1];
    assign num_mag  = num_neg ? DIV_W'(-num_reg) : DIV_W'(num_reg);
    assign limit    = num_neg ? {1'b1, {(SKEW_W - 1){1'b0}}} : {1'b0, {(SKEW_W - 1){1'b1}}};
    assign skew_sat = ((|skq_reg[DIV_W-1:SKEW_W]) || (skq_reg[SKEW_W-1:0] > limit))
                      ? limit : skq_reg[SKEW_W-1:0];

    always_comb
    begin
        unique case (step_reg)
            2'd0:    mul_b = dd_mag_reg[MB_W-1:0];
            2'd1:    mul_b = MB_W'(dd_mag_reg[DDM_W-1:MB_W]);
            2'd2:    mul_b = dl_mag_reg[MB_W-1:0];
            default: mul_b = MB_W'(dl_mag_reg[DLM_W-1:MB_W]);
        endcase
    end

    always_comb
    begin
        unique case (acc_step_reg)
            2'd1, 2'd3: acc_ext = DIV_W'(prod_reg) << MB_W;
            default:    acc_ext = DIV_W'(prod_reg);
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        fill_next      = fill_reg;
        base_next      = base_reg;
        rd_ptr_next    = rd_ptr_reg;
        cnt_next       = cnt_reg;
        rd_vld_next    = 1'b0;
        acc_vld_next   = 1'b0;
        step_next      = step_reg;
        acc_step_next  = step_reg;
        fit_valid_next = fit_valid_reg;
        sumd_next      = sumd_reg;
        suml_next      = suml_reg;
        off_next       = off_reg;
        mean_next      = mean_reg;
        dl_mag_next    = dl_mag_reg;
        dd_mag_next    = dd_mag_reg;
        neg_next       = neg_reg;
        prod_next      = mul_a * mul_b;
        num_next       = num_reg;
        den_next       = den_reg;
        skq_next       = skq_reg;
        status_next    = status_reg;
        skew_next      = skew_reg;
        fit_next       = fit_reg;
        mem_we         = 1'b0;
        wr_ptr         = ptr_add(base_reg, fill_reg);
        div_req        = '0;

        if (fit_valid_reg && fit_ready)
        begin
            fit_valid_next = 1'b0;
        end

        // window length writes must come only while idle; the block itself does not enforce this
        if (cfg_we)
        begin
            if (cfg_val == '0)
            begin
                len_next = LEN_W'(1);
            end
            else if (32'(cfg_val) > 32'(WINDOW_MAX))
            begin
                len_next = LEN_W'(WINDOW_MAX);
            end
            else
            begin
                len_next = LEN_W'(cfg_val);
            end
            if (32'(fill_reg) > 32'(len_next) + 1)
            begin
                base_next = ptr_add(base_reg, CNT_W'(32'(fill_reg) - 32'(len_next) - 1));
                fill_next = CNT_W'(32'(len_next) + 1);
            end
        end

        // pass one and pass two accumulators
        if (rd_vld_reg)
        begin
            sumd_next = sumd_reg + SUM_W'(diff);
            suml_next = suml_reg + SUM_W'(lo_rd_reg);
        end
        if (acc_vld_reg)
        begin
            unique case (acc_step_reg)
                2'd0, 2'd1: num_next = neg_reg ? num_reg - $signed(acc_ext)
                                               : num_reg + $signed(acc_ext);
                default:    den_next = den_reg + acc_ext;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    status_next = FIT_NOT_FULL;
                    off_next    = '0;
                    mean_next   = '0;
                    skew_next   = '0;
                    sumd_next   = '0;
                    suml_next   = '0;
                    state_next  = S_DONE;
                    if (sample.clear_window)
                    begin
                        fill_next = '0;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        if (32'(fill_reg) == 32'(len_reg) + 1)
                        begin
                            base_next = ptr_inc(base_reg);
                        end
                        else
                        begin
                            fill_next = fill_reg + 1'b1;
                        end
                        if (32'(fill_next) == 32'(len_reg) + 1)
                        begin
                            rd_ptr_next = base_next;
                            cnt_next    = '0;
                            state_next  = S_P1;
                        end
                    end
                end
            end
            S_P1:
            begin
                if (cnt_reg != len_reg)
                begin
                    rd_ptr_next = ptr_inc(rd_ptr_reg);
                    cnt_next    = cnt_reg + 1'b1;
                    rd_vld_next = 1'b1;
                end
                else if (!rd_vld_reg)
                begin
                    state_next = S_OFF_GO;
                end
            end
            S_OFF_GO:
            begin
                div_req.start = 1'b1;
                div_req.n     = DIV_CNT_W'(OFF_N);
                div_req.num   = DIV_W'(sumd_mag) << (DIV_W - SUM_W);
                div_req.den   = DIV_W'(len_reg);
                state_next    = S_OFF_WAIT;
            end
            S_OFF_WAIT:
            begin
                if (!div_busy)
                begin
                    off_next   = sumd_reg[SUM_W-1] ? -$signed(off_q + OFF_W'(off_rnd))
                                                   : $signed(off_q + OFF_W'(off_rnd));
                    state_next = S_MEAN_GO;
                end
            end
            S_MEAN_GO:
            begin
                div_req.start = 1'b1;
                div_req.n     = DIV_CNT_W'(MEAN_N);
                div_req.num   = DIV_W'(suml_reg) << (DIV_W - SUM_W);
                div_req.den   = DIV_W'(len_reg);
                state_next    = S_MEAN_WAIT;
            end
            S_MEAN_WAIT:
            begin
                if (!div_busy)
                begin
                    mean_next   = div_quo[TIME_W-1:0];
                    num_next    = '0;
                    den_next    = '0;
                    rd_ptr_next = ptr_add(base_reg, '0);
                    cnt_next    = '0;
                    state_next  = S_P2_RD;
                end
            end
            S_P2_RD:
            begin
                rd_ptr_next = ptr_inc(rd_ptr_reg);
                cnt_next    = cnt_reg + 1'b1;
                state_next  = S_P2_PREP;
            end
            S_P2_PREP:
            begin
                dl_mag_next = dl[DLM_W-1] ? DLM_W'(-dl) : DLM_W'(dl);
                dd_mag_next = dd[DD_W-1] ? DDM_W'(-dd) : DDM_W'(dd);
                neg_next    = dl[DLM_W-1] ^ dd[DD_W-1];
                step_next   = 2'd0;
                state_next  = S_P2_MUL;
            end
            S_P2_MUL:
            begin
                acc_vld_next = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == 2'd3)
                begin
                    state_next = (cnt_reg == len_reg) ? S_P2_END : S_P2_RD;
                end
            end
            S_P2_END:
            begin
                state_next = S_SKEW_GO;
            end
            S_SKEW_GO:
            begin
                if (den_reg == '0)
                begin
                    status_next = FIT_DEN_ZERO;
                    skew_next   = '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.n     = DIV_CNT_W'(SKEW_N);
                    div_req.num   = num_mag << (DIV_W - SKEW_N + 16);
                    div_req.den   = den_reg;
                    state_next    = S_SKEW_WAIT;
                end
            end
            S_SKEW_WAIT:
            begin
                if (!div_busy)
                begin
                    skq_next   = div_quo + DIV_W'(skew_rnd);
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                status_next = FIT_VALID;
                skew_next   = num_neg ? SKEW_W'(-skew_sat) : skew_sat;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!fit_valid_reg || fit_ready)
                begin
                    fit_next.fit_status = status_reg;
                    fit_next.offset_q16 = off_reg[OFFSET_W-1:0];
                    fit_next.skew_q32   = skew_reg;
                    fit_next.local_mean = mean_reg;
                    fit_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= LEN_W'(LEN_RESET);
            fill_reg      <= '0;
            base_reg      <= '0;
            rd_ptr_reg    <= '0;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            acc_vld_reg   <= 1'b0;
            step_reg      <= '0;
            acc_step_reg  <= '0;
            fit_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            fill_reg      <= fill_next;
            base_reg      <= base_next;
            rd_ptr_reg    <= rd_ptr_next;
            cnt_reg       <= cnt_next;
            rd_vld_reg    <= rd_vld_next;
            acc_vld_reg   <= acc_vld_next;
            step_reg      <= step_next;
            acc_step_reg  <= acc_step_next;
            fit_valid_reg <= fit_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sumd_reg   <= sumd_next;
        suml_reg   <= suml_next;
        off_reg    <= off_next;
        mean_reg   <= mean_next;
        dl_mag_reg <= dl_mag_next;
        dd_mag_reg <= dd_mag_next;
        neg_reg    <= neg_next;
        prod_reg   <= prod_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        skq_reg    <= skq_next;
        status_reg <= status_next;
        skew_reg   <= skew_next;
        fit_reg    <= fit_next;
    end

    // sample store, circular from base_reg
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            global_mem[wr_ptr] <= sample.global_time;
            local_mem[wr_ptr]  <= sample.local_time;
        end
        gl_rd_reg <= global_mem[ptr_inc(rd_ptr_reg)];
        lo_rd_reg <= local_mem[rd_ptr_reg];
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= 32'(len_reg) + 1)
        else $error("window holds more samples than window_len+1");

    a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(base_reg) < DEPTH)
        else $error("window base pointer out of range");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> !sample_ready)
        else $error("second transaction taken while one is in work");

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (fit_valid && (fit.fit_status == FIT_NOT_FULL)) |->
        (fit.skew_q32 == '0 && fit.offset_q16 == '0 && fit.local_mean == '0))
        else $error("short window result carries nonzero fields");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_busy)
        else $error("divider started while busy");

endmodule
